>>> rtl/core/fps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fps_pkg;

    localparam int FPS_SIZE = 1024;
    localparam int OP_W     = 2;
    localparam int POS_W    = 10;
    localparam int DELTA_W  = 16;
    localparam int SUM_W    = 32;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_QUERY = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic                    valid;
        logic signed [SUM_W-1:0] sum;
    } res_t;

endpackage

`default_nettype wire

>>> rtl/core/fenwick_prefix_sum_tree.sv
`timescale 1ns / 1ps
`default_nettype none

// Binary indexed tree of SIZE signed 32-bit cells held in one single-port-write,
// registered-read RAM. An add or a query visits one cell at a time in two steps
// (RAM read, then add; an add also writes back), keeping busy high during the walk
// and visiting at most ceil(log2(SIZE)) cells; an add at position zero or at SIZE
// and above, a query at position zero and operation code three do not raise busy.
// A query result is strobed on result_valid for one cycle right after its last busy
// cycle, and cannot be held off by the receiver. A clear, and the clearing pass after
// reset, write zero to one cell per cycle and hold busy until every cell is cleared.

module fenwick_prefix_sum_tree
    import fps_pkg::*;
#(
    parameter int SIZE = FPS_SIZE
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [OP_W-1:0]           operation,
    input  wire logic [POS_W-1:0]          position,
    input  wire logic signed [DELTA_W-1:0] delta,
    output logic                           result_valid,
    output logic signed [SUM_W-1:0]        prefix_sum
);

    localparam int AW = (SIZE > 1) ? $clog2(SIZE) : 1;

    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [SUM_W-1:0]   ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [SUM_W-1:0]   ram_rdata;
    res_t               res;

    logic                    result_valid_reg;
    logic signed [SUM_W-1:0] prefix_sum_reg;

    fps_ctrl #(
        .SIZE (SIZE)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .position  (position),
        .delta     (delta),
        .busy      (busy),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .res       (res)
    );

    fps_ram #(
        .WIDTH (SUM_W),
        .DEPTH (SIZE)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // register the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            prefix_sum_reg <= res.sum;
        end
    end

    assign result_valid = result_valid_reg;
    assign prefix_sum   = prefix_sum_reg;

    a_no_write_idle : assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !ram_we)
        else $error("RAM written while idle");

    a_query_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == OP_QUERY) && (position == '0))
        |=> (result_valid && (prefix_sum == '0)))
        else $error("query at position zero did not return zero");

    a_add_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == OP_ADD) && (position == '0)) |=> !busy)
        else $error("add at position zero started a walk");

    a_clear_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == OP_CLEAR)) |=> (busy && !result_valid))
        else $error("clear did not start its sweep");

endmodule

`default_nettype wire

>>> rtl/core/fps_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module fps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/fps_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module fps_ctrl
    import fps_pkg::*;
#(
    parameter int SIZE = FPS_SIZE,
    localparam int AW  = (SIZE > 1) ? $clog2(SIZE) : 1,
    localparam int IDX_W = ((AW > POS_W) ? AW : POS_W) + 1
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic [OP_W-1:0]           operation,
    input  wire logic [POS_W-1:0]          position,
    input  wire logic signed [DELTA_W-1:0] delta,
    output logic                           busy,
    output logic                           ram_we,
    output logic [AW-1:0]                  ram_waddr,
    output logic [SUM_W-1:0]               ram_wdata,
    output logic [AW-1:0]                  ram_raddr,
    input  wire logic [SUM_W-1:0]          ram_rdata,
    output res_t                           res
);

    localparam logic [IDX_W-1:0] SIZE_IDX = IDX_W'(SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SIZE - 1);
    localparam logic [AW-1:0]    LAST_ADR = AW'(SIZE - 1);

    state_t                     state_reg, state_next;
    logic [IDX_W-1:0]           idx_reg, idx_next;
    logic                       query_reg, query_next;
    logic [DELTA_W-1:0]         delta_reg, delta_next;
    logic [SUM_W-1:0]           acc_reg, acc_next;
    logic [AW-1:0]              clr_cnt_reg, clr_cnt_next;

    logic                       accept;
    logic [IDX_W-1:0]           pos_ext;
    logic                       add_go;
    logic                       query_zero;
    logic [IDX_W-1:0]           low_bit;
    logic [IDX_W-1:0]           idx_up;
    logic [IDX_W-1:0]           idx_down;
    logic                       walk_more;
    logic [SUM_W-1:0]           delta_ext;
    logic [SUM_W-1:0]           acc_sum;

    assign accept     = start && (state_reg == ST_IDLE);
    assign pos_ext    = IDX_W'(position);
    assign add_go     = (position != '0) && (pos_ext < SIZE_IDX);
    assign query_zero = (position == '0);

    // upward walk adds the lowest set bit, downward walk drops it
    assign low_bit   = idx_reg & (~idx_reg + IDX_W'(1));
    assign idx_up    = idx_reg + low_bit;
    assign idx_down  = idx_reg & (idx_reg - IDX_W'(1));
    assign walk_more = query_reg ? (idx_down != '0) : (idx_up < SIZE_IDX);

    assign delta_ext = {{(SUM_W-DELTA_W){delta_reg[DELTA_W-1]}}, delta_reg};
    assign acc_sum   = acc_reg + ram_rdata;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == LAST_ADR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op_t'(operation))
                        OP_ADD:   state_next = add_go ? ST_READ : ST_IDLE;
                        OP_QUERY: state_next = query_zero ? ST_IDLE : ST_READ;
                        OP_CLEAR: state_next = ST_CLEAR;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = walk_more ? ST_READ : ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath registers
    always_comb
    begin
        idx_next     = idx_reg;
        query_next   = query_reg;
        delta_next   = delta_reg;
        acc_next     = acc_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
            end
            ST_IDLE:
            begin
                query_next   = (op_t'(operation) == OP_QUERY);
                delta_next   = delta;
                acc_next     = '0;
                clr_cnt_next = '0;
                // saturate an out-of-range query to the last cell
                idx_next     = (pos_ext > LAST_IDX) ? LAST_IDX : pos_ext;
            end
            ST_UPDATE:
            begin
                acc_next = acc_sum;
                idx_next = query_reg ? idx_down : idx_up;
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy      = (state_reg != ST_IDLE);
        ram_we    = 1'b0;
        ram_waddr = idx_reg[AW-1:0];
        ram_wdata = ram_rdata + delta_ext;
        ram_raddr = idx_reg[AW-1:0];
        res.valid = 1'b0;
        res.sum   = acc_sum;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            ST_IDLE:
            begin
                if (accept && (op_t'(operation) == OP_QUERY) && query_zero)
                begin
                    res.valid = 1'b1;
                    res.sum   = '0;
                end
            end
            ST_UPDATE:
            begin
                ram_we    = !query_reg;
                res.valid = query_reg && !walk_more;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            query_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            query_reg   <= query_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        delta_reg <= delta_next;
        acc_reg   <= acc_next;
    end

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import fps_pkg::*;

    localparam logic [OP_W-1:0] OP_NONE = 2'd3;  // unused code, block ignores it
    localparam int WALK_CYCLES = 2 * POS_W + 4;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic [POS_W-1:0]          pos;
        logic signed [DELTA_W-1:0] amount;
        logic                      pinned;
        logic signed [SUM_W-1:0]   sum;
    } row_t;

    // Directed rows: pinned sums are fixed by hand, the rest come from the tree model.
    localparam int N_ROWS = 23;
    localparam row_t ROWS [0:N_ROWS-1] = '{
        '{OP_QUERY, 10'd1023, 16'h0000, 1'b1, 32'h0000_0000},
        '{OP_QUERY, 10'd0,    16'h0000, 1'b1, 32'h0000_0000},
        '{OP_NONE,  10'd5,    16'h1234, 1'b0, 32'h0000_0000},
        '{OP_ADD,   10'd1,    16'h7FFF, 1'b0, 32'h0000_0000},
        '{OP_ADD,   10'd1023, 16'h8000, 1'b0, 32'h0000_0000},
        '{OP_ADD,   10'd0,    16'h04D2, 1'b0, 32'h0000_0000},
        '{OP_QUERY, 10'd0,    16'hFFFF, 1'b1, 32'h0000_0000},
        '{OP_QUERY, 10'd1023, 16'h0000, 1'b1, 32'hFFFF_FFFF},
        '{OP_QUERY, 10'd1,    16'h0000, 1'b1, 32'h0000_7FFF},
        '{OP_QUERY, 10'd1022, 16'h0000, 1'b1, 32'h0000_7FFF},
        '{OP_ADD,   10'd512,  16'hFFFF, 1'b0, 32'h0000_0000},
        '{OP_QUERY, 10'd511,  16'h0000, 1'b1, 32'h0000_7FFF},
        '{OP_QUERY, 10'd512,  16'h0000, 1'b1, 32'h0000_7FFE},
        '{OP_ADD,   10'd768,  16'h8000, 1'b0, 32'h0000_0000},
        '{OP_QUERY, 10'd800,  16'h0000, 1'b0, 32'h0000_0000},
        '{OP_NONE,  10'd1023, 16'hFFFF, 1'b0, 32'h0000_0000},
        '{OP_QUERY, 10'd1023, 16'h0000, 1'b1, 32'hFFFF_7FFE},
        '{OP_CLEAR, 10'd0,    16'h0000, 1'b0, 32'h0000_0000},
        '{OP_QUERY, 10'd1023, 16'h0000, 1'b1, 32'h0000_0000},
        '{OP_QUERY, 10'd1,    16'h0000, 1'b1, 32'h0000_0000},
        '{OP_ADD,   10'd1023, 16'h0001, 1'b0, 32'h0000_0000},
        '{OP_QUERY, 10'd1022, 16'h0000, 1'b1, 32'h0000_0000},
        '{OP_QUERY, 10'd1023, 16'h0000, 1'b1, 32'h0000_0001}
    };

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      start = 1'b0;
    logic [OP_W-1:0]           operation = OP_ADD;
    logic [POS_W-1:0]          position = '0;
    logic signed [DELTA_W-1:0] delta = '0;
    logic                      busy;
    logic                      result_valid;
    logic signed [SUM_W-1:0]   prefix_sum;

    // hand-pinned sum travels with the beat it belongs to
    logic                      beat_pinned = 1'b0;
    logic signed [SUM_W-1:0]   beat_sum = '0;

    logic [SUM_W-1:0]          tree_cells [0:FPS_SIZE-1];
    logic signed [SUM_W-1:0]   pending_sums [$];
    logic signed [SUM_W-1:0]   want_sum;
    int                        errors = 0;

    fenwick_prefix_sum_tree dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .position     (position),
        .delta        (delta),
        .result_valid (result_valid),
        .prefix_sum   (prefix_sum)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    task automatic clear_tree();
        for (int i = 0; i < FPS_SIZE; i++)
        begin
            tree_cells[i] = '0;
        end
    endtask

    task automatic tree_point_add(input logic [POS_W-1:0] pos,
                                  input logic signed [DELTA_W-1:0] amount);
        int unsigned idx;
        idx = 32'(pos);
        // position zero never advances: drop it
        if (idx != 0)
        begin
            while (idx < FPS_SIZE)
            begin
                tree_cells[idx] = tree_cells[idx] + {{(SUM_W-DELTA_W){amount[DELTA_W-1]}}, amount};
                idx = idx + (idx & (~idx + 1));
            end
        end
    endtask

    function automatic logic [SUM_W-1:0] tree_prefix_sum(input logic [POS_W-1:0] pos);
        int unsigned      idx;
        logic [SUM_W-1:0] acc;
        idx = 32'(pos);
        acc = '0;
        if (idx >= FPS_SIZE)
            idx = FPS_SIZE - 1;
        while (idx > 0)
        begin
            acc = acc + tree_cells[idx];
            idx = idx - (idx & (~idx + 1));
        end
        return acc;
    endfunction

    initial
    begin
        clear_tree();
    end

    // Check strobed sums first, then fold in the beat accepted at this edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (pending_sums.size() == 0)
                begin
                    $display("%0t: unexpected prefix_sum, expected none, actual %0d",
                             $time, prefix_sum);
                    errors++;
                end
                else
                begin
                    want_sum = pending_sums.pop_front();
                    if (prefix_sum !== want_sum)
                    begin
                        $display("%0t: prefix_sum mismatch, expected %0d, actual %0d",
                                 $time, want_sum, prefix_sum);
                        errors++;
                    end
                end
            end
            if (start && !busy)
            begin
                case (operation)
                    OP_ADD:   tree_point_add(position, delta);
                    OP_QUERY: pending_sums = {pending_sums,
                                              (beat_pinned ? beat_sum
                                                           : tree_prefix_sum(position))};
                    OP_CLEAR: clear_tree();
                    default:  ;
                endcase
            end
        end
    end

    // Present one beat, hold it until accepted, then idle for a random gap.
    task automatic issue_command(input logic [OP_W-1:0] op,
                                 input logic [POS_W-1:0] pos,
                                 input logic signed [DELTA_W-1:0] amount,
                                 input logic pinned,
                                 input logic signed [SUM_W-1:0] sum,
                                 input int idle_pct);
        int gap;
        start       <= 1'b1;
        operation   <= op;
        position    <= pos;
        delta       <= amount;
        beat_pinned <= pinned;
        beat_sum    <= sum;
        do
            @(posedge clk);
        while (busy);
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic random_command(input int idle_pct);
        logic [OP_W-1:0]           op;
        logic [POS_W-1:0]          pos;
        logic signed [DELTA_W-1:0] amount;
        int                        pick;
        pick = $urandom_range(0, 999);
        if (pick < 5)
            op = OP_CLEAR;
        else if (pick < 35)
            op = OP_NONE;
        else if (pick < 560)
            op = OP_ADD;
        else
            op = OP_QUERY;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            pos = '0;
        else if (pick == 1)
            pos = '1;
        else if (pick == 2)
            pos = 10'd1 << $urandom_range(0, POS_W - 1);
        else
            pos = POS_W'($urandom_range(0, FPS_SIZE - 1));
        pick = $urandom_range(0, 9);
        if (pick == 0)
            amount = 16'h8000;
        else if (pick == 1)
            amount = 16'h7FFF;
        else
            amount = DELTA_W'($urandom);
        issue_command(op, pos, amount, 1'b0, '0, idle_pct);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_ROWS; r++)
        begin
            issue_command(ROWS[r].op, ROWS[r].pos, ROWS[r].amount,
                          ROWS[r].pinned, ROWS[r].sum, 33);
        end

        for (int n = 0; n < 476; n++)
            random_command(33);

        // drain every pending sum before switching the idle pattern
        start <= 1'b0;
        @(posedge clk);
        while (pending_sums.size() != 0)
            @(posedge clk);

        for (int n = 0; n < 476; n++)
            random_command(77);
        for (int n = 0; n < 476; n++)
            random_command(0);

        start <= 1'b0;
        @(posedge clk);
        while (pending_sums.size() != 0 || busy)
            @(posedge clk);
        repeat (WALK_CYCLES) @(posedge clk);

        errors += pending_sums.size();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
